FILE: hdl/base64_codec_defines.svh
// Assertion macros shared by the codec modules.
// Both expect signals named aclk and aresetn in the module that uses them.
`ifndef BASE64_CODEC_DEFINES_SVH
`define BASE64_CODEC_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define B64_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define B64_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/b64_pkg.sv
package b64_pkg;

    localparam logic [7:0] PAD_CHAR    = 8'h3D;
    localparam logic       MODE_ENCODE = 1'b0;
    localparam logic       MODE_DECODE = 1'b1;

    // Job queue between front and back
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

    // One accepted item's worth of output words, first word in data[0]
    typedef struct packed {
        logic [3:0][7:0] data;
        logic [1:0]      cnt_m1;
        logic            last;
        logic            err;
    } job_t;

    typedef struct packed {
        logic       valid;
        logic [5:0] val;
    } sextet_t;

    // Map a sextet to its alphabet character
    function automatic logic [7:0] b64_enc_char(input logic [5:0] v);
        logic [7:0] c;
        c = {2'b00, v};
        case (v) inside
            [6'd0:6'd25]:  b64_enc_char = c + 8'd65;
            [6'd26:6'd51]: b64_enc_char = c + 8'd71;
            [6'd52:6'd61]: b64_enc_char = c - 8'd4;
            6'd62:         b64_enc_char = 8'h2B;
            default:       b64_enc_char = 8'h2F;
        endcase
    endfunction

    // Map a character back to its sextet; valid low if outside the alphabet
    function automatic sextet_t b64_dec_char(input logic [7:0] c);
        sextet_t s;
        s.valid = 1'b1;
        case (c) inside
            [8'h41:8'h5A]: s.val = 6'(c - 8'h41);
            [8'h61:8'h7A]: s.val = 6'(c - 8'h47);
            [8'h30:8'h39]: s.val = 6'(c + 8'h04);
            8'h2B:         s.val = 6'd62;
            8'h2F:         s.val = 6'd63;
            default: begin
                s.valid = 1'b0;
                s.val   = 6'd0;
            end
        endcase
        return s;
    endfunction

endpackage

FILE: hdl/b64_front.sv
module b64_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_valid,
    input  logic          cfg_data,
    input  logic          s_tvalid,
    input  logic [7:0]    s_tdata,
    input  logic          s_tlast,
    output logic          s_tready,
    input  logic          fifo_full,
    output logic          push,
    output b64_pkg::job_t push_job
);
    import b64_pkg::*;

    logic        mode_reg, mode_next;
    logic [23:0] gb_reg, gb_next;
    logic [1:0]  pos_reg, pos_next;
    logic [1:0]  pad_reg, pad_next;
    logic        err_reg, err_next;

    logic        accept;
    logic        have_out;
    logic        done;
    logic [1:0]  pos_inc;
    logic [23:0] enc_bits;
    logic [11:0] enc_one;
    logic [17:0] enc_two;
    sextet_t     dec;

    assign s_tready = !fifo_full;
    assign accept   = s_tvalid && s_tready;

    assign pos_inc  = pos_reg + 2'd1;
    assign enc_bits = {gb_reg[15:0], s_tdata};
    assign enc_one  = {s_tdata, 4'b0000};
    assign enc_two  = {enc_bits[15:0], 2'b00};
    assign dec      = b64_dec_char(s_tdata);

    // Classify the incoming word, update the group and build its job
    always_comb begin
        mode_next = mode_reg;
        gb_next   = gb_reg;
        pos_next  = pos_reg;
        pad_next  = pad_reg;
        err_next  = err_reg;
        have_out  = 1'b0;
        done      = 1'b0;
        push_job  = '0;
        push      = 1'b0;

        if (cfg_valid) begin
            mode_next = cfg_data;
            gb_next   = '0;
            pos_next  = '0;
            pad_next  = '0;
            err_next  = 1'b0;
        end else if (accept) begin
            if (mode_reg == MODE_ENCODE) begin
                gb_next  = enc_bits;
                pos_next = pos_inc;
                if (pos_inc == 2'd3) begin
                    push_job.data[0] = b64_enc_char(enc_bits[23:18]);
                    push_job.data[1] = b64_enc_char(enc_bits[17:12]);
                    push_job.data[2] = b64_enc_char(enc_bits[11:6]);
                    push_job.data[3] = b64_enc_char(enc_bits[5:0]);
                    push_job.cnt_m1  = 2'd3;
                    have_out         = 1'b1;
                    gb_next          = '0;
                    pos_next         = '0;
                end else if (s_tlast) begin
                    if (pos_inc == 2'd1) begin
                        push_job.data[0] = b64_enc_char(enc_one[11:6]);
                        push_job.data[1] = b64_enc_char(enc_one[5:0]);
                        push_job.data[2] = PAD_CHAR;
                    end else begin
                        push_job.data[0] = b64_enc_char(enc_two[17:12]);
                        push_job.data[1] = b64_enc_char(enc_two[11:6]);
                        push_job.data[2] = b64_enc_char(enc_two[5:0]);
                    end
                    push_job.data[3] = PAD_CHAR;
                    push_job.cnt_m1  = 2'd3;
                    have_out         = 1'b1;
                end
            end else begin
                if (s_tdata == PAD_CHAR) begin
                    if (pad_reg == 2'd0 && pos_reg == 2'd2) begin
                        gb_next  = {gb_reg[17:0], 6'd0};
                        pos_next = 2'd3;
                        pad_next = 2'd1;
                    end else if (pad_reg == 2'd0 && pos_reg == 2'd3) begin
                        gb_next  = {gb_reg[17:0], 6'd0};
                        pad_next = 2'd1;
                        done     = 1'b1;
                    end else if (pad_reg == 2'd1 && pos_reg == 2'd3) begin
                        gb_next  = {gb_reg[17:0], 6'd0};
                        pad_next = 2'd2;
                        done     = 1'b1;
                    end else begin
                        err_next = 1'b1;
                    end
                end else if (!dec.valid || pad_reg != 2'd0) begin
                    // drop characters outside the alphabet or after padding
                    err_next = 1'b1;
                end else begin
                    gb_next = {gb_reg[17:0], dec.val};
                    if (pos_reg == 2'd3) begin
                        done = 1'b1;
                    end else begin
                        pos_next = pos_inc;
                    end
                end

                if (done) begin
                    push_job.data[0] = gb_next[23:16];
                    push_job.data[1] = gb_next[15:8];
                    push_job.data[2] = gb_next[7:0];
                    push_job.cnt_m1  = 2'd2 - pad_next;
                    have_out         = 1'b1;
                    gb_next          = '0;
                    pos_next         = '0;
                end
                // a message ending mid-group is truncated
                if (s_tlast && pos_next != 2'd0) begin
                    err_next = 1'b1;
                end
            end

            // report the end of every message, even with nothing to emit
            if (s_tlast && !have_out) begin
                push_job.data   = '0;
                push_job.cnt_m1 = 2'd0;
            end
            push_job.last = s_tlast;
            push_job.err  = err_next;
            push          = have_out || s_tlast;

            if (s_tlast) begin
                gb_next  = '0;
                pos_next = '0;
                pad_next = '0;
                err_next = 1'b0;
            end
        end
    end

    // Hold mode and group state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_ENCODE;
            gb_reg   <= '0;
            pos_reg  <= '0;
            pad_reg  <= '0;
            err_reg  <= 1'b0;
        end else begin
            mode_reg <= mode_next;
            gb_reg   <= gb_next;
            pos_reg  <= pos_next;
            pad_reg  <= pad_next;
            err_reg  <= err_next;
        end
    end

endmodule

FILE: hdl/b64_fifo.sv
`include "base64_codec_defines.svh"

module b64_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  b64_pkg::job_t push_job,
    input  logic          pop,
    output b64_pkg::job_t pop_job,
    output logic          not_empty,
    output logic          full
);
    import b64_pkg::*;

    localparam logic [FIFO_AW:0] DEPTH_CNT = (FIFO_AW + 1)'(FIFO_DEPTH);
    localparam logic [FIFO_AW-1:0] LAST_PTR = FIFO_AW'(FIFO_DEPTH - 1);

    job_t               entry_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   count_reg, count_next;

    assign not_empty = count_reg != '0;
    assign full      = count_reg == DEPTH_CNT;
    assign pop_job   = entry_reg[rd_ptr_reg];

    // Advance pointers and the fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed job
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    `B64_ASSERT_SAME(a_no_push_full, push, !full || pop, "job pushed into a full queue")
    `B64_ASSERT_SAME(a_no_pop_empty, pop, not_empty, "job popped from an empty queue")
    `B64_ASSERT_NEXT(a_count_step, push && !pop, count_reg != '0, "fill count lost a push")

endmodule

FILE: hdl/b64_back.sv
`include "base64_codec_defines.svh"

module b64_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          job_valid,
    input  b64_pkg::job_t job,
    output logic          pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,
    output logic          m_tlast,
    output logic          m_tuser
);
    import b64_pkg::*;

    job_t       cur_reg;
    logic       cur_valid_reg, cur_valid_next;
    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_data_reg;
    logic       out_last_reg;
    logic       out_err_reg;

    logic       out_load;
    logic       final_word;

    assign final_word = idx_reg == cur_reg.cnt_m1;
    assign out_load   = cur_valid_reg && (!out_valid_reg || m_tready);
    assign pop        = job_valid && (!cur_valid_reg || (out_load && final_word));

    // Step through the job into the output register, one word per cycle unless stalled
    always_comb begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (out_load) begin
            out_valid_next = 1'b1;
            idx_next       = idx_reg + 2'd1;
            if (final_word) begin
                cur_valid_next = 1'b0;
            end
        end
        if (pop) begin
            cur_valid_next = 1'b1;
            idx_next       = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: take a new job, load the output word
    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg <= job;
        end
        if (out_load) begin
            out_data_reg <= cur_reg.data[idx_reg];
            out_last_reg <= cur_reg.last && final_word;
            out_err_reg  <= cur_reg.err;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_err_reg;

    `B64_ASSERT_SAME(a_idx_in_job, cur_valid_reg, idx_reg <= cur_reg.cnt_m1, "word index past job end")

endmodule

FILE: hdl/base64_codec.sv
// Streaming Base64 codec, standard alphabet with '=' padding.
// Input words arrive on s_tvalid/s_tready/s_tdata/s_tlast: s_tdata[7:0] is a raw
// byte (encode) or a Base64 character (decode); s_tlast closes a message and
// flushes a partial group. Results leave on m_tvalid/m_tready/m_tdata with
// m_tlast on the final word of a message and m_tuser as the sticky error flag.
// cfg_valid/cfg_ready/cfg_data writes the mode (0 encode, 1 decode); a write
// also abandons any partial message. The user must issue it only while the codec
// is idle; the block itself does not enforce this. An accepted item passes through
// the queue entry, the current-job register and the output register. The output
// side moves one word per cycle while the receiver is ready, so the output
// serialiser sets the pace: encode gives four words per three bytes, decode three
// words per four characters (one character per cycle). A two-entry job queue
// sits between the input classifier and the serialiser, so input is taken
// while results wait. When the receiver stalls, the output register holds its
// word and the queue fills; s_tready falls once both queue entries are taken.
// Reset (aresetn low, synchronous) selects encode mode and clears control state.
module base64_codec (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,
    output logic       m_tuser    // [0] error
);
    import b64_pkg::*;

    job_t push_job;
    job_t pop_job;
    logic push;
    logic pop;
    logic fifo_full;
    logic fifo_not_empty;

    assign cfg_ready = 1'b1;

    b64_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tready  (s_tready),
        .fifo_full (fifo_full),
        .push      (push),
        .push_job  (push_job)
    );

    b64_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .pop_job   (pop_job),
        .not_empty (fifo_not_empty),
        .full      (fifo_full)
    );

    b64_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (fifo_not_empty),
        .job       (pop_job),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

FILE: tb/tb_base64_codec.sv
module tb_base64_codec;
    import b64_pkg::*;

    // One result word as it leaves the codec
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       err;
    } codec_word_t;

    // Bit-true model of the codec plus the words it still owes
    class codec_board;
        logic          dec_mode;
        logic [23:0]   grp;
        logic [1:0]    pos;
        logic [1:0]    pads;
        logic          err;
        codec_word_t   owed_words[$];
        int            faults;

        function new();
            faults = 0;
            set_mode(MODE_ENCODE);
        endfunction

        // A mode write also drops any partial message
        function void set_mode(logic m);
            dec_mode = m;
            grp      = '0;
            pos      = '0;
            pads     = '0;
            err      = 1'b0;
        endfunction

        static function logic [7:0] glyph(logic [5:0] v);
            if (v < 26) return 8'h41 + 8'(v);
            if (v < 52) return 8'h61 + 8'(v - 26);
            if (v < 62) return 8'h30 + 8'(v - 52);
            if (v == 62) return 8'h2B;
            return 8'h2F;
        endfunction

        static function int sextet(logic [7:0] c);
            if (c >= 8'h41 && c <= 8'h5A) return int'(c) - 'h41;
            if (c >= 8'h61 && c <= 8'h7A) return int'(c) - 'h61 + 26;
            if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30 + 52;
            if (c == 8'h2B) return 62;
            if (c == 8'h2F) return 63;
            return -1;
        endfunction

        function void owe(logic [7:0] b);
            codec_word_t w;
            w.ch   = b;
            w.last = 1'b0;
            w.err  = 1'b0;
            owed_words.push_back(w);
        endfunction

        // Work out the words caused by one accepted input word
        function void take_input(logic [7:0] d, logic l);
            int          first;
            int          s;
            int          k;
            bit          done;
            logic [17:0] v;
            first = owed_words.size();
            done  = 0;
            if (dec_mode == MODE_ENCODE) begin
                grp = {grp[15:0], d};
                pos = pos + 2'd1;
                if (pos == 2'd3) begin
                    owe(glyph(grp[23:18]));
                    owe(glyph(grp[17:12]));
                    owe(glyph(grp[11:6]));
                    owe(glyph(grp[5:0]));
                    pos = '0;
                    grp = '0;
                end else if (l) begin
                    if (pos == 2'd1) begin
                        v = {6'd0, grp[7:0], 4'd0};
                        owe(glyph(v[11:6]));
                        owe(glyph(v[5:0]));
                        owe(PAD_CHAR);
                        owe(PAD_CHAR);
                    end else begin
                        v = {grp[15:0], 2'd0};
                        owe(glyph(v[17:12]));
                        owe(glyph(v[11:6]));
                        owe(glyph(v[5:0]));
                        owe(PAD_CHAR);
                    end
                end
            end else begin
                s = sextet(d);
                if (d == PAD_CHAR) begin
                    if (pads == 2'd0 && pos == 2'd2) begin
                        grp  = grp << 6;
                        pos  = 2'd3;
                        pads = 2'd1;
                    end else if (pads == 2'd0 && pos == 2'd3) begin
                        grp  = grp << 6;
                        pads = 2'd1;
                        done = 1;
                    end else if (pads == 2'd1 && pos == 2'd3) begin
                        grp  = grp << 6;
                        pads = 2'd2;
                        done = 1;
                    end else begin
                        err = 1'b1;
                    end
                end else if (s < 0) begin
                    err = 1'b1;
                end else if (pads != 2'd0) begin
                    err = 1'b1;
                end else begin
                    grp = {grp[17:0], 6'(s)};
                    pos = pos + 2'd1;
                    if (pos == 2'd0) begin
                        pos  = 2'd3;
                        done = 1;
                    end
                end
                if (done) begin
                    owe(grp[23:16]);
                    if (pads < 2'd2) owe(grp[15:8]);
                    if (pads == 2'd0) owe(grp[7:0]);
                    pos = '0;
                    grp = '0;
                end
                if (l && pos != 2'd0) err = 1'b1;
            end
            // A last word always reports, even with nothing to emit
            if (l && owed_words.size() == first) owe(8'h00);
            for (k = first; k < owed_words.size(); k++) owed_words[k].err = err;
            if (l) begin
                owed_words[owed_words.size() - 1].last = 1'b1;
                set_mode(dec_mode);
            end
        endfunction

        task report(string what, logic [7:0] got, logic [7:0] want);
            if (faults < 100)
                $display("mismatch on %s: got %02h, want %02h", what, got, want);
            faults++;
        endtask

        // Compare one result word with the oldest owed word
        task check_word(logic [7:0] d, logic l, logic e);
            codec_word_t w;
            if (owed_words.size() == 0) begin
                report("unowed word", d, 8'h00);
            end else begin
                w = owed_words.pop_front();
                if (d !== w.ch) report("out_byte", d, w.ch);
                if (l !== w.last) report("out_last", 8'(l), 8'(w.last));
                if (e !== w.err) report("error", 8'(e), 8'(w.err));
            end
        endtask
    endclass

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_data  = 1'b0;
    logic       s_tvalid  = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata   = 8'h00;   // [7:0] data_byte
    logic       s_tlast   = 1'b0;
    logic       m_tvalid;
    logic       m_tready  = 1'b0;
    logic [7:0] m_tdata;             // [7:0] out_byte
    logic       m_tlast;
    logic       m_tuser;             // [0] error

    codec_board board;
    bit         calm = 0;
    int         sent = 0;
    logic [7:0] raw[$];
    logic [7:0] msg[$];

    base64_codec dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function bit idle_now();
        return !calm && ($urandom_range(99) < 6);
    endfunction

    // Stall the receiver now and then
    always @(posedge aclk) begin
        m_tready <= !idle_now();
    end

    // Check every word that leaves the codec
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_word(m_tdata, m_tlast, m_tuser);
    end

    // Offer one word and hold it until taken; valid stays high afterwards
    task automatic send_item(logic [7:0] d, logic l);
        while (idle_now()) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= l;
        do @(posedge aclk); while (!s_tready);
        board.take_input(d, l);
        sent++;
    endtask

    task automatic send_text(string t);
        int i;
        for (i = 0; i < t.len(); i++) send_item(t[i], i == t.len() - 1);
    endtask

    task automatic send_msg();
        int i;
        for (i = 0; i < msg.size(); i++) send_item(msg[i], i == msg.size() - 1);
    endtask

    // Wait until every owed word has arrived and the pipeline has drained
    task automatic settle();
        s_tvalid <= 1'b0;
        while (board.owed_words.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic write_mode(logic m);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.set_mode(m);
    endtask

    // Encode raw bytes into msg as well-formed Base64 text
    task automatic build_b64();
        int          i;
        int          left;
        logic [23:0] v;
        msg.delete();
        for (i = 0; i < raw.size(); i += 3) begin
            left = raw.size() - i;
            v = {raw[i], (left > 1) ? raw[i+1] : 8'h00, (left > 2) ? raw[i+2] : 8'h00};
            msg.push_back(codec_board::glyph(v[23:18]));
            msg.push_back(codec_board::glyph(v[17:12]));
            msg.push_back((left > 1) ? codec_board::glyph(v[11:6]) : PAD_CHAR);
            msg.push_back((left > 2) ? codec_board::glyph(v[5:0]) : PAD_CHAR);
        end
    endtask

    task automatic enc_phase(int items, bit leave_open);
        int start;
        start = sent;
        while (sent - start < items) begin
            msg.delete();
            repeat ($urandom_range(1, 8)) msg.push_back(8'($urandom_range(255)));
            send_msg();
        end
        // Leave a partial group for the next mode write to drop
        if (leave_open) repeat ($urandom_range(1, 2)) send_item(8'($urandom_range(255)), 1'b0);
    endtask

    task automatic dec_phase(int items, bit leave_open);
        int start;
        int roll;
        start = sent;
        while (sent - start < items) begin
            raw.delete();
            repeat ($urandom_range(1, 7)) raw.push_back(8'($urandom_range(255)));
            build_b64();
            roll = $urandom_range(99);
            if (roll < 75) begin
                // well-formed text, nothing to do
            end else if (roll < 82) begin
                msg[$urandom_range(msg.size() - 1)] = 8'($urandom_range(255));
            end else if (roll < 89) begin
                repeat ($urandom_range(1, 3)) if (msg.size() > 1) void'(msg.pop_back());
            end else if (roll < 95) begin
                msg.insert($urandom_range(msg.size()), PAD_CHAR);
            end else begin
                msg.delete();
                repeat ($urandom_range(1, 6)) begin
                    if ($urandom_range(1)) msg.push_back(8'($urandom_range(255)));
                    else msg.push_back(codec_board::glyph(6'($urandom_range(63))));
                end
            end
            send_msg();
        end
        if (leave_open) begin
            send_item(8'h54, 1'b0);
            send_item(8'h57, 1'b0);
        end
    endtask

    initial begin
        board = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Encode flushes: one byte, two bytes, full group closed by last
        send_text("M");
        send_text("Ma");
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b1);

        write_mode(MODE_DECODE);
        // Double pad with stray trailing bits, then a character after it
        send_text("TR==A");
        // Single pad with stray trailing bits
        send_text("TWF=");
        // Pad in first place, nothing to emit on last
        send_text("=");
        // Character after a single pad in third place
        send_text("TW=A");
        // Top of the alphabet, then an invalid character closing a short group
        send_text("/+0*");

        dec_phase(50, 1'b1);
        write_mode(MODE_ENCODE);
        enc_phase(50, 1'b1);
        write_mode(MODE_DECODE);
        calm = 1;
        dec_phase(35, 1'b0);
        calm = 0;
        dec_phase(35, 1'b0);
        write_mode(MODE_ENCODE);
        enc_phase(40, 1'b0);

        settle();
        if (board.faults == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog for a hung handshake
    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
